[src/cv3_pkg.sv]
// Package for the 3x3 valid convolution with ReLU: shared constants,
// register indexes and the control struct handed to the window cells.
// No dependencies.
package cv3_pkg;

  localparam int KERNEL_DIM      = 3;
  localparam int WEIGHT_BITS     = 16;
  localparam int FRAC_BITS       = 8;
  localparam int OUT_BITS        = 15;
  localparam int OUT_MAX         = 32767;
  localparam int WIDTH_BITS      = 6;
  localparam int KROW_BITS       = KERNEL_DIM * WEIGHT_BITS;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = KROW_BITS;

  localparam int MAX_WIDTH_DEF   = 32;
  localparam int PIXEL_BITS_DEF  = 16;
  localparam int MIN_WIDTH       = 3;
  localparam logic [WIDTH_BITS-1:0] LINE_WIDTH_RESET = WIDTH_BITS'(28);

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_WIDTH    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_TOP    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_MIDDLE = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_BOTTOM = 2'd3;

  // Per-cycle enables for every cell of the window chain
  typedef struct packed {
    logic shift;      // take the column from the right-hand neighbour
    logic load_prod;  // register the three products
    logic load_sum;   // register the column sum
  } cell_ctl_t;

endpackage

[src/cv3_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cv3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/cv3_cell.sv]
// One window column cell: holds three pixels, multiplies them by its column
// of weights and sums the products. Depends on cv3_pkg.
module cv3_cell #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                                                  clk,
  input  cv3_pkg::cell_ctl_t                                    ctl,
  input  logic [cv3_pkg::KERNEL_DIM-1:0][cv3_pkg::WEIGHT_BITS-1:0] weights,
  input  logic [cv3_pkg::KERNEL_DIM-1:0][PIXEL_BITS-1:0]        col_in,
  output logic [cv3_pkg::KERNEL_DIM-1:0][PIXEL_BITS-1:0]        col_out,
  output logic signed [PIXEL_BITS+cv3_pkg::WEIGHT_BITS+1:0]     col_sum
);
  import cv3_pkg::*;

  localparam int ProdW = PIXEL_BITS + WEIGHT_BITS;
  localparam int SumW  = ProdW + 2;

  logic [KERNEL_DIM-1:0][PIXEL_BITS-1:0] pix;
  logic signed [ProdW-1:0]               prod [KERNEL_DIM];

  assign col_out = pix;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      pix <= col_in;
    end
    if (ctl.load_prod) begin
      for (int i = 0; i < KERNEL_DIM; i++) begin
        prod[i] <= ProdW'($signed(pix[i]) * $signed(weights[i]));
      end
    end
    if (ctl.load_sum) begin
      col_sum <= SumW'(prod[0]) + SumW'(prod[1]) + SumW'(prod[2]);
    end
  end

endmodule

[src/conv3x3_valid_relu.sv]
// Top level of the streaming 3x3 valid convolution with ReLU and saturation.
// Depends on cv3_pkg, cv3_ram and cv3_cell.
//
//   Channel  | Handshake                  | Payload
//   ---------+----------------------------+------------------------------
//   pixel    | pixel_valid / pixel_stall  | pixel_in (signed Q7.8)
//   result   | result_valid / result_stall| conv_out, last_of_image
//   config   | cfg_wr_en                  | cfg_index, cfg_data
//
// Throughput: one pixel per cycle while results are not stalled; a result
// leaves once its pixel has passed the line store read, window shift,
// products, column sums and rectify/saturate stages. The rate is set by the
// nine multipliers in the three-cell window chain and the one read and one
// write port of each line store RAM.
// Reset: synchronous, clears counters, stage valids and kernel rows, sets the
// reset line width; line stores need no clearing pass, stale data gives no result.
// Stalls: each stage holds while the next one is full and stalled, so
// bubbles close up and a pixel is taken while a result waits.
module conv3x3_valid_relu #(
  parameter int MAX_WIDTH  = cv3_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = cv3_pkg::PIXEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // pixel channel
  input  logic                                pixel_valid,
  output logic                                pixel_stall,
  input  logic signed [PIXEL_BITS-1:0]        pixel_in,
  // result channel
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [cv3_pkg::OUT_BITS-1:0]        conv_out,
  output logic                                last_of_image,
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [cv3_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [cv3_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import cv3_pkg::*;

  localparam int AW    = $clog2(MAX_WIDTH);        // column / row counter width
  localparam int EW    = $clog2(MAX_WIDTH + 1);    // effective width
  localparam int CmpW  = (EW > WIDTH_BITS) ? EW : WIDTH_BITS;
  localparam int SumW  = PIXEL_BITS + WEIGHT_BITS + 2;
  localparam int AccW  = SumW + 2;
  localparam int ShW   = AccW - FRAC_BITS;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [WIDTH_BITS-1:0] line_width;
  logic [KROW_BITS-1:0]  kernel_row [KERNEL_DIM];

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RESET;
      for (int i = 0; i < KERNEL_DIM; i++) begin
        kernel_row[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LINE_WIDTH:    line_width    <= cfg_data[WIDTH_BITS-1:0];
        REG_KERNEL_TOP:    kernel_row[0] <= cfg_data[KROW_BITS-1:0];
        REG_KERNEL_MIDDLE: kernel_row[1] <= cfg_data[KROW_BITS-1:0];
        REG_KERNEL_BOTTOM: kernel_row[2] <= cfg_data[KROW_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the programmed width into the supported range
  logic [CmpW-1:0] lw_ext;
  logic [EW-1:0]   eff_w;

  always_comb begin
    lw_ext = CmpW'(line_width);
    if (lw_ext < CmpW'(MIN_WIDTH)) begin
      eff_w = EW'(MIN_WIDTH);
    end else if (lw_ext > CmpW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(lw_ext);
    end
  end

  // ---------------------------------------------------------------------
  // Stage readiness: a stage loads when it is empty or its content leaves
  // ---------------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic ready1, ready2, ready3, ready4, ready5;
  logic accept;

  assign ready5      = !result_valid || !result_stall;
  assign ready4      = !s4_valid || ready5;
  assign ready3      = !s3_valid || ready4;
  assign ready2      = !s2_valid || ready3;
  assign ready1      = !s1_valid || ready2;
  assign pixel_stall = !ready1;
  assign accept      = pixel_valid && ready1;

  // ---------------------------------------------------------------------
  // Raster counters, advanced on each accepted transaction, cleared by a width write
  // ---------------------------------------------------------------------
  logic [AW-1:0] column_count;
  logic [AW-1:0] row_count;
  logic          last_col, last_row, emit, last_px;

  assign last_col = (EW'(column_count) == eff_w - EW'(1));
  assign last_row = (EW'(row_count) == eff_w - EW'(1));
  assign emit     = (row_count >= AW'(KERNEL_DIM - 1)) &&
                    (column_count >= AW'(KERNEL_DIM - 1));
  assign last_px  = last_col && last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_wr_en && cfg_index == REG_LINE_WIDTH) begin
      // restart the map with the next pixel
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + AW'(1);
      end else begin
        column_count <= column_count + AW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: line store read, pixel and tags held alongside
  // ---------------------------------------------------------------------
  logic [AW-1:0]         s1_col;
  logic                  s1_emit, s1_last;
  logic [PIXEL_BITS-1:0] s1_px;
  logic [PIXEL_BITS-1:0] up_rd, lo_rd;
  logic                  ls_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ready1) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col  <= column_count;
      s1_emit <= emit;
      s1_last <= last_px;
      s1_px   <= pixel_in;
    end
  end

  // Write back as the transaction leaves stage 1: upper takes the old lower
  // row, lower takes the new pixel.
  assign ls_wr = s1_valid && ready2;

  cv3_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_upper (
    .clk     (clk),
    .wr_en   (ls_wr),
    .wr_addr (s1_col),
    .wr_data (lo_rd),
    .rd_en   (accept),
    .rd_addr (column_count),
    .rd_data (up_rd)
  );

  cv3_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_lower (
    .clk     (clk),
    .wr_en   (ls_wr),
    .wr_addr (s1_col),
    .wr_data (s1_px),
    .rd_en   (accept),
    .rd_addr (column_count),
    .rd_data (lo_rd)
  );

  // ---------------------------------------------------------------------
  // Stages 2 to 4: the window chain. Cell 0 holds the oldest column.
  // ---------------------------------------------------------------------
  logic      s2_last, s3_last, s4_last;
  cell_ctl_t ctl;

  assign ctl.shift     = s1_valid && ready2;
  assign ctl.load_prod = s2_valid && ready3;
  assign ctl.load_sum  = s3_valid && ready4;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      // drop transactions that give no result once they have shifted in
      if (ready2) s2_valid <= s1_valid && s1_emit;
      if (ready3) s3_valid <= s2_valid;
      if (ready4) s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift)     s2_last <= s1_last;
    if (ctl.load_prod) s3_last <= s2_last;
    if (ctl.load_sum)  s4_last <= s3_last;
  end

  logic [KERNEL_DIM-1:0][PIXEL_BITS-1:0] new_col;
  logic [KERNEL_DIM-1:0][PIXEL_BITS-1:0] cell_col [KERNEL_DIM];
  logic signed [SumW-1:0]                cell_sum [KERNEL_DIM];

  assign new_col[0] = up_rd;
  assign new_col[1] = lo_rd;
  assign new_col[2] = s1_px;

  for (genvar k = 0; k < KERNEL_DIM; k++) begin : g_cell
    logic [KERNEL_DIM-1:0][WEIGHT_BITS-1:0] wt;
    logic [KERNEL_DIM-1:0][PIXEL_BITS-1:0]  col_feed;

    for (genvar i = 0; i < KERNEL_DIM; i++) begin : g_wt
      assign wt[i] = kernel_row[i][WEIGHT_BITS*k +: WEIGHT_BITS];
    end

    if (k == KERNEL_DIM - 1) begin : g_head
      assign col_feed = new_col;
    end else begin : g_link
      assign col_feed = cell_col[k+1];
    end

    cv3_cell #(
      .PIXEL_BITS (PIXEL_BITS)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .weights (wt),
      .col_in  (col_feed),
      .col_out (cell_col[k]),
      .col_sum (cell_sum[k])
    );
  end

  // ---------------------------------------------------------------------
  // Stage 5: total, rectify, shift and saturate into the output register
  // ---------------------------------------------------------------------
  logic signed [AccW-1:0] acc;
  logic [ShW-1:0]         shifted;
  logic [OUT_BITS-1:0]    res;

  always_comb begin
    acc     = AccW'(cell_sum[0]) + AccW'(cell_sum[1]) + AccW'(cell_sum[2]);
    shifted = acc[AccW-1:FRAC_BITS];
    if (acc <= 0) begin
      res = '0;
    end else if (shifted > ShW'(OUT_MAX)) begin
      res = OUT_BITS'(OUT_MAX);
    end else begin
      res = shifted[OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready5) begin
      result_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready5 && s4_valid) begin
      conv_out      <= res;
      last_of_image <= s4_last;
    end
  end

endmodule

[tb/tb.sv]
// Testbench for conv3x3_valid_relu: streams square maps with random stalls on
// both channels and checks every result against a cycle-free predictor.
// Depends on cv3_pkg and conv3x3_valid_relu.
`timescale 1ns / 100ps

module tb;
  import cv3_pkg::*;

  localparam int          PX_BITS      = PIXEL_BITS_DEF;
  localparam int unsigned LIMIT_CYCLES = 200000;
  // the pipeline is five stages deep; allow a margin on top
  localparam int          DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [OUT_BITS-1:0] conv;
    logic                last;
  } conv_result_t;

  // DUT ports, all inputs driven to known values from time zero
  logic                       clk          = 1'b0;
  logic                       rst          = 1'b1;
  logic                       pixel_valid  = 1'b0;
  logic                       pixel_stall;
  logic signed [PX_BITS-1:0]  pixel_in     = '0;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  logic [OUT_BITS-1:0]        conv_out;
  logic                       last_of_image;
  logic                       cfg_wr_en    = 1'b0;
  logic [CFG_INDEX_BITS-1:0]  cfg_index    = '0;
  logic [CFG_DATA_BITS-1:0]   cfg_data     = '0;

  // when set, neither side idles
  bit steady = 1'b0;

  // predictor state: registers, line stores, window and map position
  logic [WIDTH_BITS-1:0]      map_width_reg;
  logic [KROW_BITS-1:0]       kernel_row [KERNEL_DIM];
  logic signed [PX_BITS-1:0]  older_row  [MAX_WIDTH_DEF];
  logic signed [PX_BITS-1:0]  newer_row  [MAX_WIDTH_DEF];
  logic signed [PX_BITS-1:0]  win        [KERNEL_DIM][KERNEL_DIM];
  int unsigned                col_pos;
  int unsigned                row_pos;

  conv_result_t pending_results [$];
  conv_result_t oldest;
  int           error_count = 0;
  int unsigned  cycle_count = 0;

  conv3x3_valid_relu uut (
    .clk           (clk),
    .rst           (rst),
    .pixel_valid   (pixel_valid),
    .pixel_stall   (pixel_stall),
    .pixel_in      (pixel_in),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .conv_out      (conv_out),
    .last_of_image (last_of_image),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Effective map side: clamp the register into the supported range.
  function automatic int unsigned map_side();
    if (map_width_reg < MIN_WIDTH) return MIN_WIDTH;
    if (map_width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return 32'(map_width_reg);
  endfunction

  // Advance the predictor by one accepted pixel and queue the result it
  // causes, if the full 3x3 window fits at this position.
  function automatic void predict_conv(input logic signed [PX_BITS-1:0] px);
    int unsigned               side;
    int unsigned               c;
    int unsigned               r;
    logic signed [PX_BITS-1:0] up;
    logic signed [PX_BITS-1:0] lo;
    longint                    acc;
    longint                    wt;
    conv_result_t              res;
    side = map_side();
    c    = col_pos;
    r    = row_pos;
    up   = older_row[c];
    lo   = newer_row[c];
    // shift the window left and bring in the new column, oldest row on top
    for (int i = 0; i < KERNEL_DIM; i++)
      for (int j = 0; j < KERNEL_DIM - 1; j++)
        win[i][j] = win[i][j+1];
    win[0][KERNEL_DIM-1] = up;
    win[1][KERNEL_DIM-1] = lo;
    win[2][KERNEL_DIM-1] = px;
    older_row[c] = lo;
    newer_row[c] = px;
    if (r >= KERNEL_DIM - 1 && c >= KERNEL_DIM - 1) begin
      acc = 0;
      for (int i = 0; i < KERNEL_DIM; i++)
        for (int j = 0; j < KERNEL_DIM; j++) begin
          wt  = longint'($signed(kernel_row[i][WEIGHT_BITS*j +: WEIGHT_BITS]));
          acc += wt * longint'(win[i][j]);
        end
      // rectify, truncate the fraction, then saturate
      if (acc <= 0)
        res.conv = '0;
      else if ((acc >>> FRAC_BITS) > OUT_MAX)
        res.conv = OUT_BITS'(OUT_MAX);
      else
        res.conv = OUT_BITS'(acc >>> FRAC_BITS);
      res.last = (r == side - 1) && (c == side - 1);
      pending_results.push_back(res);
    end
    if (c + 1 >= side) begin
      col_pos = 0;
      row_pos = (r + 1 >= side) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic logic signed [PX_BITS-1:0] rand_pixel();
    // mostly small values so that sums land between the clamps
    if ($urandom_range(0, 3) == 0) return PX_BITS'($urandom);
    return PX_BITS'($urandom_range(0, 4095) - 2048);
  endfunction

  function automatic logic [KROW_BITS-1:0] rand_kernel_row(input bit full_range);
    logic [KROW_BITS-1:0] row;
    row = KROW_BITS'({$urandom, $urandom});
    if (!full_range)
      for (int j = 0; j < KERNEL_DIM; j++)
        row[WEIGHT_BITS*j +: WEIGHT_BITS] = WEIGHT_BITS'($urandom_range(0, 1023) - 512);
    return row;
  endfunction

  // Write one register while the block is idle and mirror it in the
  // predictor. Drop the enable after the write and wait with it low so writes never abut.
  task automatic set_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                         input logic [CFG_DATA_BITS-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_LINE_WIDTH: begin
        map_width_reg = data[WIDTH_BITS-1:0];
        col_pos       = 0;
        row_pos       = 0;
      end
      REG_KERNEL_TOP:    kernel_row[0] = data[KROW_BITS-1:0];
      REG_KERNEL_MIDDLE: kernel_row[1] = data[KROW_BITS-1:0];
      REG_KERNEL_BOTTOM: kernel_row[2] = data[KROW_BITS-1:0];
      default: ;
    endcase
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one pixel, holding it steady until the transaction completes.
  // Valid is left high afterwards so back-to-back pixels need no toggle.
  task automatic send_pixel(input logic signed [PX_BITS-1:0] px);
    if (!steady && $urandom_range(0, 99) < 10) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_in    <= px;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    predict_conv(px);
  endtask

  // Drop valid and hold off until every queued result has arrived, then
  // let the pipeline empty of pixels that cause no result.
  task automatic settle();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Width written below the minimum, most negative weights and pixels:
  // the sum overflows high and must saturate; single result is the last.
  task automatic test_saturated_map();
    set_reg(REG_LINE_WIDTH, '0);
    set_reg(REG_KERNEL_TOP,    {KERNEL_DIM{16'h8000}});
    set_reg(REG_KERNEL_MIDDLE, {KERNEL_DIM{16'h8000}});
    set_reg(REG_KERNEL_BOTTOM, {KERNEL_DIM{16'h8000}});
    repeat (9) send_pixel(16'sh8000);
    settle();
  endtask

  // Abandon a map part way, rewrite the width to restart it, then drive a
  // strongly negative sum through the largest positive weights.
  task automatic test_restart_negative();
    set_reg(REG_KERNEL_TOP,    {KERNEL_DIM{16'h7FFF}});
    set_reg(REG_KERNEL_MIDDLE, {KERNEL_DIM{16'h7FFF}});
    set_reg(REG_KERNEL_BOTTOM, {KERNEL_DIM{16'h7FFF}});
    repeat (4) send_pixel(PX_BITS'($urandom));
    settle();
    set_reg(REG_LINE_WIDTH, CFG_DATA_BITS'(2));
    for (int i = 0; i < 9; i++)
      send_pixel(i == 4 ? 16'sh7FFF : 16'sh8000);
    settle();
  endtask

  // Mostly whole maps of small sizes with random weights, plus broken maps
  // and phases that carry on from where the previous one stopped.
  task automatic test_random_maps();
    int                       sent;
    int unsigned              side;
    int unsigned              count;
    logic [CFG_DATA_BITS-1:0] data;
    sent = 0;
    while (sent < 180) begin
      if ($urandom_range(0, 3) != 0) begin
        // junk in the upper bits must be ignored
        data = CFG_DATA_BITS'({$urandom, $urandom});
        data[WIDTH_BITS-1:0] = ($urandom_range(0, 9) == 0) ?
                               WIDTH_BITS'($urandom_range(0, 2)) :
                               WIDTH_BITS'($urandom_range(3, 7));
        set_reg(REG_LINE_WIDTH, data);
      end
      for (int k = 0; k < KERNEL_DIM; k++)
        if ($urandom_range(0, 2) != 0)
          set_reg(CFG_INDEX_BITS'(REG_KERNEL_TOP + k),
                  rand_kernel_row(1'($urandom_range(0, 1))));
      side = map_side();
      case ($urandom_range(0, 3))
        0:       count = $urandom_range(1, side * side);
        1:       count = 2 * side * side;
        default: count = side * side;
      endcase
      repeat (count) send_pixel(rand_pixel());
      sent += count;
      settle();
    end
  endtask

  // Widest map, set directly and by an oversized width that clamps to it.
  // Run the first part with no idling on either side.
  task automatic test_widest_maps();
    logic [CFG_DATA_BITS-1:0] data;
    steady = 1'b1;
    set_reg(REG_LINE_WIDTH, CFG_DATA_BITS'(MAX_WIDTH_DEF));
    for (int k = 0; k < KERNEL_DIM; k++)
      set_reg(CFG_INDEX_BITS'(REG_KERNEL_TOP + k), rand_kernel_row(1'b0));
    repeat (2 * MAX_WIDTH_DEF + $urandom_range(8, 40)) send_pixel(rand_pixel());
    settle();
    steady = 1'b0;
    data = CFG_DATA_BITS'({$urandom, $urandom});
    data[WIDTH_BITS-1:0] = '1;
    set_reg(REG_LINE_WIDTH, data);
    repeat (2 * MAX_WIDTH_DEF + $urandom_range(8, 40)) send_pixel(rand_pixel());
    settle();
  endtask

  // Receiver: stall at random unless a steady stretch is running.
  always @(posedge clk) begin
    result_stall <= !steady && ($urandom_range(0, 99) < 20);
  end

  // Compare every completed result transaction with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: conv_out %0d last_of_image %0b",
               conv_out, last_of_image);
        error_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (conv_out !== oldest.conv) begin
          $error("conv_out: expected %0d, got %0d", oldest.conv, conv_out);
          error_count++;
        end
        if (last_of_image !== oldest.last) begin
          $error("last_of_image: expected %0b, got %0b", oldest.last, last_of_image);
          error_count++;
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    // predictor starts from the reset state of the block
    map_width_reg = LINE_WIDTH_RESET;
    col_pos       = 0;
    row_pos       = 0;
    for (int k = 0; k < KERNEL_DIM; k++) begin
      kernel_row[k] = '0;
      for (int j = 0; j < KERNEL_DIM; j++)
        win[k][j] = '0;
    end
    for (int c = 0; c < MAX_WIDTH_DEF; c++) begin
      older_row[c] = '0;
      newer_row[c] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_saturated_map();
    test_restart_negative();
    test_random_maps();
    test_widest_maps();

    // every test ends settled; allow the pipeline latency once more
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
src/cv3_pkg.sv
src/cv3_ram.sv
src/cv3_cell.sv
src/conv3x3_valid_relu.sv
tb/tb.sv
